// ===== rtl/bpm_pkg.sv =====
// Shared constants and types for the Bayer plane median filter.
// Used by bpm_ctrl, bpm_datapath and the top level; no dependencies.
package bpm_pkg;

  localparam int MaxWidth   = 1024;
  localparam int MaxHeight  = 4096;
  localparam int Rad        = 4;
  localparam int WinSize    = 2 * Rad + 1;
  localparam int RingDepth  = (4 * Rad + 1) * MaxWidth;
  localparam int MedianRank = (WinSize * WinSize) / 2;

  localparam int PixW   = 8;
  localparam int FwW    = 11;
  localparam int FhW    = 13;
  localparam int CfgW   = 13;
  localparam int IdxW   = 23;
  localparam int RaddrW = 15;
  localparam int RowW   = 12;
  localparam int ColW   = 10;
  localparam int CntW   = 7;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [FwW-1:0] FwReset = 11'd640;
  localparam logic [FhW-1:0] FhReset = 13'd480;

  typedef struct packed {
    logic take;
    logic sel_init;
    logic pass_start;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic emit_ok;
    logic pass_done;
    logic last_bit;
    logic out_busy;
  } sts_t;

endpackage

// ===== rtl/bayer_plane_median_9x9.sv =====
// Plane-wise 9x9 median filter for raw Bayer frames.
// Depends on bpm_pkg, bpm_ctrl and bpm_datapath.
//
// Usage:
//   Stream the frame in raster order on the s_axis request channel: tuser = 0
//   carries a pixel in tdata[7:0], tuser = 1 is a drain tick. Each pixel is
//   filtered with the median of the 81 same-plane samples around it, edges
//   replicated. Results leave in raster order on m_axis, tlast on the final
//   pixel of the frame, after which all position counters restart.
//   An output is due once input has run 8 rows plus 8 pixels ahead of it;
//   after the last pixel, send one drain tick per remaining output.
// Operation:
//   A request that causes no result retires after the emit check. For one that
//   causes a result the median is found bit by bit, each of the 8 passes reading
//   all 81 window samples through the single read port of the line ring (17408
//   entries) via the address pipeline. No new request is taken until it is done.
// Configuration:
//   cfg_we_i writes frame_width (index 0) or frame_height (index 1) and resets
//   the frame position; write only while the block is idle.
// Reset and stall:
//   Reset clears counters and restores 640 x 480. The ring needs no clearing.
//   A stalled result holds in the output register; the next request is still
//   accepted and its computation runs, waiting only to load that register.
module bayer_plane_median_9x9 (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,   // [7:0] pixel
  input  logic                     s_axis_tuser,   // [0] kind
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [7:0]               m_axis_tdata,   // [7:0] filtered_pixel
  output logic                     m_axis_tlast,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [bpm_pkg::CfgW-1:0] cfg_data_i
);

  bpm_pkg::cmd_t cmd;
  bpm_pkg::sts_t sts;

  bpm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  bpm_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .kind_i     (s_axis_tuser),
    .pixel_i    (s_axis_tdata),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .m_ready_i  (m_axis_tready),
    .m_valid_o  (m_axis_tvalid),
    .m_data_o   (m_axis_tdata),
    .m_last_o   (m_axis_tlast)
  );

`ifndef SYNTHESIS
  // Never load a result over one still waiting to be taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("result loaded while output stalled");

  // A pass can only finish while the block is busy.
  a_pass_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.pass_done |-> !s_axis_tready)
    else $error("pass finished while accepting requests");

  // An accepted request is followed by a busy cycle for the emit check.
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted back to back");
`endif

endmodule

// ===== rtl/bpm_ctrl.sv =====
// Sequencer for the Bayer plane median filter.
// Drives bpm_datapath through bpm_pkg::cmd_t and reads bpm_pkg::sts_t.
module bpm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  input  bpm_pkg::sts_t sts_i,
  output bpm_pkg::cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_PASS  = 2'd2;
  localparam logic [1:0] ST_HOLD  = 2'd3;

  logic [1:0] state_q, state_d;

  assign s_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.emit_ok) begin
          cmd_o.sel_init   = 1'b1;
          cmd_o.pass_start = 1'b1;
          state_d          = ST_PASS;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PASS: begin
        if (sts_i.pass_done) begin
          if (sts_i.last_bit) begin
            state_d = ST_HOLD;
          end else begin
            cmd_o.pass_start = 1'b1;
          end
        end
      end
      ST_HOLD: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/bpm_datapath.sv =====
// Datapath of the Bayer plane median filter: registers, position counters,
// line ring memory, window address pipeline, radix select and output register.
// Depends on bpm_pkg.
module bpm_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [bpm_pkg::CfgW-1:0]   cfg_data_i,
  input  logic                       kind_i,
  input  logic [bpm_pkg::PixW-1:0]   pixel_i,
  input  bpm_pkg::cmd_t              cmd_i,
  output bpm_pkg::sts_t              sts_o,
  input  logic                       m_ready_i,
  output logic                       m_valid_o,
  output logic [bpm_pkg::PixW-1:0]   m_data_o,
  output logic                       m_last_o
);

  localparam logic [bpm_pkg::RaddrW-1:0] RingLast = bpm_pkg::RaddrW'(bpm_pkg::RingDepth - 1);
  localparam logic signed [17:0] RingS = 18'(bpm_pkg::RingDepth);

  // Configuration and effective frame size
  logic [bpm_pkg::FwW-1:0] fw_q;
  logic [bpm_pkg::FhW-1:0] fh_q;
  logic [bpm_pkg::FwW-1:0] w_eff, fw_even;
  logic [bpm_pkg::FhW-1:0] h_eff, fh_even;
  logic [bpm_pkg::IdxW-1:0] total_q;

  always_comb begin
    fw_even = {fw_q[bpm_pkg::FwW-1:1], 1'b0};
    fh_even = {fh_q[bpm_pkg::FhW-1:1], 1'b0};
    w_eff = fw_even;
    if (fw_even < 11'd2) w_eff = 11'd2;
    if (fw_even > 11'(bpm_pkg::MaxWidth)) w_eff = 11'(bpm_pkg::MaxWidth);
    h_eff = fh_even;
    if (fh_even < 13'd2) h_eff = 13'd2;
    if (fh_even > 13'(bpm_pkg::MaxHeight)) h_eff = 13'(bpm_pkg::MaxHeight);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= bpm_pkg::FwReset;
      fh_q <= bpm_pkg::FhReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == bpm_pkg::REG_FRAME_WIDTH) begin
        fw_q <= cfg_data_i[bpm_pkg::FwW-1:0];
      end else begin
        fh_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= bpm_pkg::IdxW'(w_eff * h_eff);
  end

  // Position counters
  logic [bpm_pkg::IdxW-1:0]   in_idx_q, out_idx_q;
  logic [bpm_pkg::RaddrW-1:0] wr_addr_q, out_addr_q;
  logic [bpm_pkg::RowW-1:0]   out_row_q;
  logic [bpm_pkg::ColW-1:0]   out_col_q;
  logic [bpm_pkg::IdxW:0]     lag_end;
  logic                       wr_en, frame_last;

  assign wr_en      = cmd_i.take && !kind_i && (in_idx_q < total_q);
  assign frame_last = ((out_idx_q + 23'd1) == total_q);
  assign lag_end    = {1'b0, out_idx_q} + 24'({w_eff, 3'b000}) + 24'd9;

  assign sts_o.emit_ok = (out_idx_q < total_q) &&
                         !((in_idx_q < total_q) && ({1'b0, in_idx_q} < lag_end));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_idx_q   <= '0;
      wr_addr_q  <= '0;
      out_idx_q  <= '0;
      out_addr_q <= '0;
      out_row_q  <= '0;
      out_col_q  <= '0;
    end else if (cfg_we_i || (cmd_i.emit && frame_last)) begin
      in_idx_q   <= '0;
      wr_addr_q  <= '0;
      out_idx_q  <= '0;
      out_addr_q <= '0;
      out_row_q  <= '0;
      out_col_q  <= '0;
    end else begin
      if (wr_en) begin
        in_idx_q  <= in_idx_q + 23'd1;
        wr_addr_q <= (wr_addr_q == RingLast) ? '0 : wr_addr_q + 15'd1;
      end
      if (cmd_i.emit) begin
        out_idx_q  <= out_idx_q + 23'd1;
        out_addr_q <= (out_addr_q == RingLast) ? '0 : out_addr_q + 15'd1;
        if (({1'b0, out_col_q} + 11'd1) >= w_eff) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + 12'd1;
        end else begin
          out_col_q <= out_col_q + 10'd1;
        end
      end
    end
  end

  // Tap issue: one window position per cycle, rows outer, columns inner
  logic       iss_act_q;
  logic [3:0] dy_q, dx_q;
  logic       iss_last;

  assign iss_last = (dy_q == 4'(bpm_pkg::WinSize - 1)) && (dx_q == 4'(bpm_pkg::WinSize - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_act_q <= 1'b0;
      dy_q      <= '0;
      dx_q      <= '0;
    end else if (cmd_i.pass_start) begin
      iss_act_q <= 1'b1;
      dy_q      <= '0;
      dx_q      <= '0;
    end else if (iss_act_q) begin
      if (iss_last) begin
        iss_act_q <= 1'b0;
      end else if (dx_q == 4'(bpm_pkg::WinSize - 1)) begin
        dx_q <= '0;
        dy_q <= dy_q + 4'd1;
      end else begin
        dx_q <= dx_q + 4'd1;
      end
    end
  end

  // Stage 1: fold the tap into the plane and form row/column deltas
  logic signed [13:0] rpos, rdiff;
  logic signed [11:0] cpos, cdiff;
  logic [12:0]        rr;
  logic [10:0]        cc;
  logic signed [5:0]  dr1_q, dc1_q;
  logic               v1_q, l1_q;

  always_comb begin
    rpos = $signed({2'b00, out_row_q}) + $signed({9'd0, dy_q, 1'b0}) - 14'sd8;
    if (rpos < 0) begin
      rr = {12'd0, out_row_q[0]};
    end else if (rpos >= $signed({1'b0, h_eff})) begin
      rr = h_eff - 13'd2 + {12'd0, out_row_q[0]};
    end else begin
      rr = rpos[12:0];
    end
    rdiff = $signed({1'b0, rr}) - $signed({2'b00, out_row_q});

    cpos = $signed({2'b00, out_col_q}) + $signed({7'd0, dx_q, 1'b0}) - 12'sd8;
    if (cpos < 0) begin
      cc = {10'd0, out_col_q[0]};
    end else if (cpos >= $signed({1'b0, w_eff})) begin
      cc = w_eff - 11'd2 + {10'd0, out_col_q[0]};
    end else begin
      cc = cpos[10:0];
    end
    cdiff = $signed({1'b0, cc}) - $signed({2'b00, out_col_q});
  end

  // Stage 2: ring offset; stage 3: wrapped ring address
  logic signed [17:0] off2_q, dr_x, dc_x, w_x, abs3;
  logic [bpm_pkg::RaddrW-1:0] rd_addr3_q;
  logic v2_q, l2_q, v3_q, l3_q, v4_q, l4_q;
  logic [bpm_pkg::PixW-1:0] rd_data_q;

  assign dr_x = 18'(dr1_q);
  assign dc_x = 18'(dc1_q);
  assign w_x  = $signed({7'd0, w_eff});
  assign abs3 = $signed({3'b000, out_addr_q}) + off2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= iss_act_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    l1_q   <= iss_last;
    dr1_q  <= rdiff[5:0];
    dc1_q  <= cdiff[5:0];
    l2_q   <= l1_q;
    off2_q <= 18'(dr_x * w_x) + dc_x;
    l3_q   <= l2_q;
    if (abs3 < 0) begin
      rd_addr3_q <= bpm_pkg::RaddrW'(abs3 + RingS);
    end else if (abs3 >= RingS) begin
      rd_addr3_q <= bpm_pkg::RaddrW'(abs3 - RingS);
    end else begin
      rd_addr3_q <= abs3[bpm_pkg::RaddrW-1:0];
    end
    l4_q <= l3_q;
  end

  // Line ring memory
  logic [bpm_pkg::PixW-1:0] ring_mem [bpm_pkg::RingDepth];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wr_addr_q] <= pixel_i;
    end
    rd_data_q <= ring_mem[rd_addr3_q];
  end

  // Radix select, one bit per pass, most significant first
  logic [bpm_pkg::PixW-1:0] prefix_q;
  logic [2:0]               bit_q;
  logic [bpm_pkg::CntW-1:0] k_q, cnt_q, cnt_sum;
  logic                     hit;

  assign hit = v4_q && (((rd_data_q ^ prefix_q) & (8'hFE << bit_q)) == 8'h00) &&
               !rd_data_q[bit_q];
  assign cnt_sum = cnt_q + {6'd0, hit};

  assign sts_o.pass_done = v4_q && l4_q;
  assign sts_o.last_bit  = (bit_q == 3'd0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sel_init) begin
      prefix_q <= '0;
      bit_q    <= 3'd7;
      k_q      <= bpm_pkg::CntW'(bpm_pkg::MedianRank);
      cnt_q    <= '0;
    end else if (v4_q) begin
      if (l4_q) begin
        cnt_q <= '0;
        bit_q <= bit_q - 3'd1;
        if (k_q < cnt_sum) begin
          prefix_q[bit_q] <= 1'b0;
        end else begin
          prefix_q[bit_q] <= 1'b1;
          k_q             <= k_q - cnt_sum;
        end
      end else begin
        cnt_q <= cnt_sum;
      end
    end
  end

  // Output register
  logic out_valid_q;
  logic [bpm_pkg::PixW-1:0] out_data_q;
  logic out_last_q;

  assign sts_o.out_busy = out_valid_q && !m_ready_i;
  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;
  assign m_last_o  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= prefix_q;
      out_last_q <= frame_last;
    end
  end

endmodule

// ===== sim/tb_bayer_plane_median_9x9.sv =====
// Self-checking testbench for bayer_plane_median_9x9: directed table, then random frames.
// Depends on bpm_pkg and the RTL top level; predicts results with its own plane median, bar typed rows.
`timescale 1ns / 1ps

module tb_bayer_plane_median_9x9;
  import bpm_pkg::*;

  localparam int HalfPeriod = 6;
  localparam int ItemTarget = 1650;
  localparam int LongHold   = 3000;

  // How a directed row's result is known: predicted, typed as none, or typed in.
  typedef enum int {BY_PREDICTOR, TYPED_NONE, TYPED_RESULT} row_check_e;
  localparam bit KIND_PIXEL = 1'b0;
  localparam bit KIND_DRAIN = 1'b1;

  typedef struct {
    logic [7:0] pix;
    logic       last;
  } filtered_t;

  typedef struct {
    bit         kind;
    logic [7:0] pix;
    row_check_e check;
    logic [7:0] exp_pix;
    logic       exp_last;
  } plan_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata = '0;
  logic             s_axis_tuser = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [7:0]       m_axis_tdata;
  logic             m_axis_tlast;
  logic             cfg_we_i = 1'b0;
  logic             cfg_idx_i = REG_FRAME_WIDTH;
  logic [CfgW-1:0]  cfg_data_i = '0;

  bayer_plane_median_9x9 DUT (.*);

  always #HalfPeriod clk_i = ~clk_i;

  // Predictor state: own copy of registers, frame position and sample ring.
  logic [FwW-1:0] width_reg = FwReset;
  logic [FhW-1:0] height_reg = FhReset;
  logic [7:0]     sample_ring [RingDepth];
  int             in_col, in_row, out_col, out_row;
  bit             frame_closed;

  filtered_t pending_medians[$];
  bit        failed = 1'b0;
  bit        hold_req = 1'b0;
  int        items_sent = 0;
  int        burst_left = 0;

  function automatic int plane_width();
    int v;
    v = int'(width_reg & 11'h7FE);
    if (v < 2) v = 2;
    if (v > MaxWidth) v = MaxWidth;
    return v;
  endfunction

  function automatic int plane_height();
    int v;
    v = int'(height_reg & 13'h1FFE);
    if (v < 2) v = 2;
    if (v > MaxHeight) v = MaxHeight;
    return v;
  endfunction

  // Replicate the nearest edge position of the same parity.
  function automatic int edge_fold(int pos, int parity, int size);
    if (pos < 0) return parity;
    if (pos >= size) return size - 2 + parity;
    return pos;
  endfunction

  function automatic logic [7:0] plane_median(int r, int c, int w, int h);
    int vals [WinSize*WinSize];
    int n, rr, cc, v, b;
    n = 0;
    for (int dy = -Rad; dy <= Rad; dy++) begin
      rr = edge_fold(r + 2 * dy, r & 1, h);
      for (int dx = -Rad; dx <= Rad; dx++) begin
        cc = edge_fold(c + 2 * dx, c & 1, w);
        vals[n] = int'(sample_ring[(rr * w + cc) % RingDepth]);
        n++;
      end
    end
    for (int a = 1; a < WinSize * WinSize; a++) begin
      v = vals[a];
      b = a - 1;
      while (b >= 0 && vals[b] > v) begin
        vals[b + 1] = vals[b];
        b--;
      end
      vals[b + 1] = v;
    end
    return vals[MedianRank][7:0];
  endfunction

  function automatic void restart_frame();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  // Advance the frame position by one request; return 1 when a result is due.
  function automatic bit median_step(bit kind, logic [7:0] pix, output filtered_t res);
    int w, h, total, lag, in_idx, out_idx;
    w = plane_width();
    h = plane_height();
    total = w * h;
    lag = 2 * Rad * w + 2 * Rad;
    res = '{pix: '0, last: 1'b0};
    if (kind == KIND_PIXEL && in_row < h) begin
      sample_ring[(in_row * w + in_col) % RingDepth] = pix;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
    end
    in_idx = in_row * w + in_col;
    out_idx = out_row * w + out_col;
    if (out_idx >= total) return 1'b0;
    if (in_idx < total && in_idx < out_idx + lag + 1) return 1'b0;
    res.pix = plane_median(out_row, out_col, w, h);
    res.last = (out_idx + 1 == total);
    if (res.last) begin
      restart_frame();
      frame_closed = 1'b1;
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    return 1'b1;
  endfunction

  // Write one register; the predictor restarts its frame at the same moment.
  task automatic write_reg(input logic idx, input int value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[CfgW-1:0];
    if (idx == REG_FRAME_WIDTH) width_reg = value[FwW-1:0];
    else height_reg = value[FhW-1:0];
    restart_frame();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Drop valid and hold until every expected result is out, then let the
  // last result-free request retire.
  task automatic drain_wait();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    burst_left = 0;
  endtask

  // Offer one request in burst/gap fashion and record what it should produce.
  task automatic offer(input bit kind, input logic [7:0] pix, input row_check_e check,
                       input logic [7:0] exp_pix, input logic exp_last);
    filtered_t res;
    bit due;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= pix;
    do @(posedge clk_i); while (!s_axis_tready);
    due = median_step(kind, pix, res);
    case (check)
      BY_PREDICTOR: if (due) pending_medians.push_back(res);
      TYPED_RESULT: pending_medians.push_back('{pix: exp_pix, last: exp_last});
      default: ;
    endcase
    burst_left--;
    items_sent++;
  endtask

  // Send one frame: mostly pixels with random content, a little drain noise
  // mid-frame, then drains (some disguised as stray pixels) until it closes.
  // A nonzero cut abandons the frame after that many requests.
  task automatic run_frame(input int w, input int h, input int cut);
    int sent;
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    frame_closed = 1'b0;
    sent = 0;
    while (!frame_closed && (cut == 0 || sent < cut)) begin
      if (in_row < plane_height())
        offer($urandom_range(0, 15) == 0 ? KIND_DRAIN : KIND_PIXEL, 8'($urandom),
              BY_PREDICTOR, '0, 1'b0);
      else
        offer($urandom_range(0, 3) == 0 ? KIND_PIXEL : KIND_DRAIN, 8'($urandom),
              BY_PREDICTOR, '0, 1'b0);
      sent++;
    end
    drain_wait();
  endtask

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    filtered_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_medians.size() == 0) begin
        $error("unexpected result filtered_pixel=%0h tlast=%0b", m_axis_tdata, m_axis_tlast);
        failed = 1'b1;
      end else begin
        want = pending_medians.pop_front();
        if (m_axis_tdata !== want.pix) begin
          $error("filtered_pixel expected %0h actual %0h", want.pix, m_axis_tdata);
          failed = 1'b1;
        end
        if (m_axis_tlast !== want.last) begin
          $error("frame_end expected %0b actual %0b", want.last, m_axis_tlast);
          failed = 1'b1;
        end
      end
    end
  end

  // Receiver: switch among random stall patterns; on request, hold
  // off for a long stretch so the block backs up into its input.
  initial begin
    int mode, left;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(50, 400);
        end
        left--;
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom);
          default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Directed part: a 2x2 frame puts each plane at a single sample, so every
  // result equals its own input pixel.
  plan_row_t plan [17];
  initial begin
    plan[0]  = '{KIND_PIXEL, 8'h00, TYPED_NONE,   8'h00, 1'b0};
    plan[1]  = '{KIND_DRAIN, 8'hFF, TYPED_NONE,   8'h00, 1'b0}; // drain too early
    plan[2]  = '{KIND_PIXEL, 8'hFF, TYPED_NONE,   8'h00, 1'b0};
    plan[3]  = '{KIND_PIXEL, 8'hA5, TYPED_NONE,   8'h00, 1'b0};
    plan[4]  = '{KIND_PIXEL, 8'h5A, TYPED_RESULT, 8'h00, 1'b0};
    plan[5]  = '{KIND_DRAIN, 8'h00, TYPED_RESULT, 8'hFF, 1'b0};
    plan[6]  = '{KIND_PIXEL, 8'h77, TYPED_RESULT, 8'hA5, 1'b0}; // stray pixel drains
    plan[7]  = '{KIND_DRAIN, 8'h00, TYPED_RESULT, 8'h5A, 1'b1};
    plan[8]  = '{KIND_DRAIN, 8'h00, TYPED_NONE,   8'h00, 1'b0}; // new frame, early
    plan[9]  = '{KIND_PIXEL, 8'h12, BY_PREDICTOR, 8'h00, 1'b0};
    plan[10] = '{KIND_PIXEL, 8'h34, BY_PREDICTOR, 8'h00, 1'b0};
    plan[11] = '{KIND_PIXEL, 8'h56, BY_PREDICTOR, 8'h00, 1'b0};
    plan[12] = '{KIND_PIXEL, 8'h78, BY_PREDICTOR, 8'h00, 1'b0};
    plan[13] = '{KIND_DRAIN, 8'h00, BY_PREDICTOR, 8'h00, 1'b0};
    plan[14] = '{KIND_DRAIN, 8'h00, BY_PREDICTOR, 8'h00, 1'b0};
    plan[15] = '{KIND_DRAIN, 8'h00, BY_PREDICTOR, 8'h00, 1'b0};
    plan[16] = '{KIND_DRAIN, 8'h00, BY_PREDICTOR, 8'h00, 1'b0};
  end

  initial begin
    for (int i = 0; i < RingDepth; i++) sample_ring[i] = '0;
    restart_frame();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    write_reg(REG_FRAME_WIDTH, 2);
    write_reg(REG_FRAME_HEIGHT, 2);
    foreach (plan[i])
      offer(plan[i].kind, plan[i].pix, plan[i].check, plan[i].exp_pix, plan[i].exp_last);
    drain_wait();

    // Size extremes: saturating sizes and the exact maxima only start a frame.
    run_frame(2047, 8191, 40);
    run_frame(MaxWidth, MaxHeight, 30);
    run_frame(0, 1, 0);        // too small, runs as 2x2
    run_frame(3, 5, 0);        // odd, rounds down to 2x4
    run_frame(16, 12, 0);      // outputs start before the input ends

    // Long receiver hold-off while the sender keeps offering.
    hold_req = 1'b1;
    run_frame(4, 4, 0);

    while (items_sent < ItemTarget) begin
      case ($urandom_range(0, 9))
        0: run_frame($urandom_range(0, 14), $urandom_range(0, 14), $urandom_range(3, 40));
        1: begin
          // Change one register only; the other keeps its last setting.
          write_reg(REG_FRAME_HEIGHT, $urandom_range(2, 12));
          frame_closed = 1'b0;
          while (!frame_closed)
            offer(in_row < plane_height() ? KIND_PIXEL : KIND_DRAIN, 8'($urandom),
                  BY_PREDICTOR, '0, 1'b0);
          drain_wait();
        end
        default: run_frame($urandom_range(0, 14), $urandom_range(0, 14), 0);
      endcase
    end

    drain_wait();
    repeat (20) @(posedge clk_i);
    if (!failed) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
